>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the frame zero-pad / resize block.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fzpr_pkg.sv
// Package for the frame zero-pad / resize block: sizes, codes and the command type.
// No dependencies; every RTL module of the block imports it.
`default_nettype none

package fzpr_pkg;

  localparam int FZ_MAX_FRAME   = 1024;
  localparam int FZ_SAMPLE_BITS = 16;
  localparam int CFG_DW         = 11;
  localparam int CFG_IW         = 2;
  localparam int QDEPTH         = 4;

  localparam logic [CFG_IW-1:0] CFG_IN_LEN  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_OUT_LEN = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ZPHASE  = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_ZERO,
    CMD_NOTREADY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      last;
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/fzpr_front.sv
// Front end: accepts requests, tracks the frame fill and output position, maps positions.
// Depends on fzpr_pkg; feeds fzpr_queue.
`default_nettype none

module fzpr_front import fzpr_pkg::*; #(
  parameter int MAX_FRAME   = FZ_MAX_FRAME,
  parameter int SAMPLE_BITS = FZ_SAMPLE_BITS,
  localparam int AW = $clog2(MAX_FRAME),
  localparam int LW = $clog2(MAX_FRAME + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_operation,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  input  logic [LW-1:0]          in_len,
  input  logic [LW-1:0]          out_len,
  input  logic                   zero_phase,
  input  logic                   q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd,
  output logic [AW-1:0]          q_addr,
  output logic [AW-1:0]          q_index,
  output logic [SAMPLE_BITS-1:0] q_data
);

  logic [LW-1:0] loaded_r, loaded_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic          accept;
  logic          frame_done;
  logic [AW-1:0] p;
  logic [LW-1:0] pe;
  logic          last;
  logic [LW-1:0] h, b, n, l;
  logic [LW-1:0] map_addr;
  logic          map_zero;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign frame_done = (loaded_r >= in_len);
  assign p          = (LW'(pos_r) >= out_len) ? '0 : pos_r;
  assign pe         = LW'(p);
  assign last       = (pe == out_len - LW'(1));

  assign h = in_len >> 1;
  assign b = (out_len - in_len) >> 1;
  assign n = out_len >> 1;
  assign l = (in_len - out_len) >> 1;

  // Position to frame address; map_zero marks padded positions.
  always_comb begin
    map_addr = pe;
    map_zero = 1'b0;
    if (out_len > in_len) begin
      if (zero_phase) begin
        if (pe < h) begin
          map_addr = pe;
        end else if (pe >= out_len - h) begin
          map_addr = pe - out_len + (h << 1);
        end else begin
          map_zero = 1'b1;
        end
      end else begin
        if (pe >= b && pe < b + in_len) begin
          map_addr = pe - b;
        end else begin
          map_zero = 1'b1;
        end
      end
    end else if (out_len < in_len) begin
      if (zero_phase) begin
        if (pe < n) begin
          map_addr = pe;
        end else if (pe < (n << 1)) begin
          map_addr = in_len - (n << 1) + pe;
        end else begin
          map_zero = 1'b1;
        end
      end else begin
        map_addr = l + pe;
      end
    end
  end

  always_comb begin
    loaded_nxt = loaded_r;
    pos_nxt    = pos_r;
    q_push     = 1'b0;
    q_cmd.kind = CMD_WRITE;
    q_cmd.last = 1'b0;
    q_addr     = AW'(loaded_r);
    q_index    = '0;
    q_data     = in_sample_in;
    if (accept) begin
      if (in_operation == OP_PUSH) begin
        if (!frame_done) begin
          q_push     = 1'b1;
          loaded_nxt = loaded_r + LW'(1);
        end
      end else if (!frame_done) begin
        q_push     = 1'b1;
        q_cmd.kind = CMD_NOTREADY;
      end else begin
        q_push     = 1'b1;
        q_cmd.kind = map_zero ? CMD_ZERO : CMD_READ;
        q_cmd.last = last;
        q_addr     = AW'(map_addr);
        q_index    = p;
        if (last) begin
          pos_nxt    = '0;
          loaded_nxt = '0;
        end else begin
          pos_nxt = p + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      pos_r    <= '0;
    end else begin
      loaded_r <= loaded_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fzpr_queue.sv
// Short first-in first-out queue of commands between front and back end.
// Depends on fzpr_pkg for its depth.
`default_nettype none

module fzpr_queue import fzpr_pkg::*; #(
  parameter int WIDTH = 8,
  localparam int PW = $clog2(QDEPTH),
  localparam int CW = $clog2(QDEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [QDEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? wr_r + PW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + PW'(1) : rd_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fzpr_back.sv
// Back end: frame memory, registered read stage and the output register.
// Depends on fzpr_pkg; drains fzpr_queue.
`default_nettype none

module fzpr_back import fzpr_pkg::*; #(
  parameter int MAX_FRAME   = FZ_MAX_FRAME,
  parameter int SAMPLE_BITS = FZ_SAMPLE_BITS,
  localparam int AW = $clog2(MAX_FRAME)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  cmd_t                   q_cmd,
  input  logic [AW-1:0]          q_addr,
  input  logic [AW-1:0]          q_index,
  input  logic [SAMPLE_BITS-1:0] q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample_out,
  output logic [AW-1:0]          out_index,
  output logic                   out_last_of_frame,
  output logic                   out_status
);

  logic [SAMPLE_BITS-1:0] mem [MAX_FRAME];
  logic [SAMPLE_BITS-1:0] mem_q;
  logic                   s1_valid_r, s1_valid_nxt;
  cmd_t                   s1_cmd_r;
  logic [AW-1:0]          s1_index_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic [AW-1:0]          out_index_r;
  logic                   out_last_r;
  logic                   out_status_r;
  logic                   head_write;
  logic                   s1_move;
  logic                   s1_load;

  assign head_write = (q_cmd.kind == CMD_WRITE);
  assign s1_move    = s1_valid_r && (!out_valid_r || out_ready);
  assign q_pop      = !q_empty && (head_write || !s1_valid_r || s1_move);
  assign s1_load    = q_pop && !head_write;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // At most one memory access per cycle: the write of a sample or the read of a stored sample.
  always_ff @(posedge clk) begin
    if (q_pop && head_write) begin
      mem[q_addr] <= q_data;
    end
    if (q_pop && q_cmd.kind == CMD_READ) begin
      mem_q <= mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cmd_r   <= q_cmd;
      s1_index_r <= q_index;
    end
    if (s1_move) begin
      out_sample_r <= (s1_cmd_r.kind == CMD_READ) ? mem_q : '0;
      out_index_r  <= s1_index_r;
      out_last_r   <= s1_cmd_r.last;
      out_status_r <= (s1_cmd_r.kind == CMD_NOTREADY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_index         = out_index_r;
  assign out_last_of_frame = out_last_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire

>>> hw/rtl/frame_zero_pad_resize.sv
// Top level of the frame zero-pad / resize block: configuration registers and wiring.
// Depends on fzpr_pkg, fzpr_front, fzpr_queue, fzpr_back and assert_macros.svh.
//
// Channel   Direction  Handshake               Payload
// in_       request    in_valid / in_ready     in_operation, in_sample_in
// out_      result     out_valid / out_ready   out_sample_out, out_index,
//                                              out_last_of_frame, out_status
// cfg_      write      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request is taken per cycle while the command queue has room; the single port of
// the frame memory is used at most once per push or pull, and that port sets the rate.
// A pull is registered in the command queue, then in the read stage and then in the
// output register, which raises out_valid for the result.
// A push gives no result. The configuration port is always ready.
// Reset is synchronous and active low; the frame memory needs no clearing pass.
// A stalled output leaves two results in the back end, one in the read stage and one in
// the output register; pulls then fill the four-entry queue and the input stops.
`default_nettype none
`include "assert_macros.svh"

module frame_zero_pad_resize import fzpr_pkg::*; #(
  parameter int MAX_FRAME   = FZ_MAX_FRAME,
  parameter int SAMPLE_BITS = FZ_SAMPLE_BITS,
  localparam int AW = $clog2(MAX_FRAME),
  localparam int LW = $clog2(MAX_FRAME + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_operation,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample_out,
  output logic [AW-1:0]          out_index,
  output logic                   out_last_of_frame,
  output logic                   out_status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IW-1:0]      cfg_index,
  input  logic [CFG_DW-1:0]      cfg_data
);

  localparam int QW = $bits(cmd_t) + 2 * AW + SAMPLE_BITS;

  // Lengths are kept already clamped to the legal range 1 to MAX_FRAME.
  logic [LW-1:0]          in_len_r, in_len_nxt;
  logic [LW-1:0]          out_len_r, out_len_nxt;
  logic                   zp_r, zp_nxt;
  logic [LW-1:0]          len_clamped;
  logic                   cfg_we;

  logic                   q_push, q_pop, q_full, q_empty;
  cmd_t                   f_cmd, b_cmd;
  logic [AW-1:0]          f_addr, f_index, b_addr, b_index;
  logic [SAMPLE_BITS-1:0] f_data, b_data;
  logic [QW-1:0]          q_wdata, q_head;

  logic                   nr_clean;
  logic                   last_ok;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // A zero length counts as one, a length above the frame memory as its full size.
  always_comb begin
    if (cfg_data == '0) begin
      len_clamped = LW'(1);
    end else if (32'(cfg_data) > 32'(MAX_FRAME)) begin
      len_clamped = LW'(MAX_FRAME);
    end else begin
      len_clamped = LW'(cfg_data);
    end
  end

  always_comb begin
    in_len_nxt  = in_len_r;
    out_len_nxt = out_len_r;
    zp_nxt      = zp_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IN_LEN:  in_len_nxt  = len_clamped;
        CFG_OUT_LEN: out_len_nxt = len_clamped;
        CFG_ZPHASE:  zp_nxt      = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_len_r  <= LW'(1);
      out_len_r <= LW'(1);
      zp_r      <= 1'b1;
    end else begin
      in_len_r  <= in_len_nxt;
      out_len_r <= out_len_nxt;
      zp_r      <= zp_nxt;
    end
  end

  // The front end classifies each request and updates fill count and output position.
  fzpr_front #(
    .MAX_FRAME   (MAX_FRAME),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_sample_in (in_sample_in),
    .in_len       (in_len_r),
    .out_len      (out_len_r),
    .zero_phase   (zp_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (f_cmd),
    .q_addr       (f_addr),
    .q_index      (f_index),
    .q_data       (f_data)
  );

  assign q_wdata = {f_cmd, f_addr, f_index, f_data};

  fzpr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {b_cmd, b_addr, b_index, b_data} = q_head;

  // The back end owns the frame memory and the output register.
  fzpr_back #(
    .MAX_FRAME   (MAX_FRAME),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_cmd             (b_cmd),
    .q_addr            (b_addr),
    .q_index           (b_index),
    .q_data            (b_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_index         (out_index),
    .out_last_of_frame (out_last_of_frame),
    .out_status        (out_status)
  );

  assign nr_clean = (out_sample_out == '0) && (out_index == '0) && !out_last_of_frame;
  assign last_ok  = (out_index == AW'(out_len_r - LW'(1)));

  // A not-ready result is all zero apart from its status.
  `FZ_ASSERT_IMP(a_notready_clean, out_valid && out_status, nr_clean, "not-ready result has data")
  // The final sample of a frame sits at the last position of the output length.
  `FZ_ASSERT_IMP(a_last_index, out_valid && out_last_of_frame, last_ok, "last at wrong index")

endmodule

`default_nettype wire

>>> tb/frame_resize_checker.sv
`timescale 1ns / 100ps
// Checker for the frame zero-pad / resize block: predicts every pull result and compares it.
// Depends on fzpr_pkg for sizes, register indexes and operation codes.

module frame_resize_checker import fzpr_pkg::*; (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_operation,
  input  logic [FZ_SAMPLE_BITS-1:0]       in_sample_in,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [FZ_SAMPLE_BITS-1:0]       out_sample_out,
  input  logic [$clog2(FZ_MAX_FRAME)-1:0] out_index,
  input  logic                            out_last_of_frame,
  input  logic                            out_status,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [CFG_IW-1:0]               cfg_index,
  input  logic [CFG_DW-1:0]               cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  localparam int   IDX_W            = $clog2(FZ_MAX_FRAME);
  localparam int   REPORT_LIMIT     = 10;
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef struct packed {
    logic [FZ_SAMPLE_BITS-1:0] sample;
    logic [IDX_W-1:0]          index;
    logic                      last;
    logic                      status;
  } frame_result_t;

  logic [FZ_SAMPLE_BITS-1:0] frame_mem [FZ_MAX_FRAME];
  logic [CFG_DW-1:0]         in_len_reg;
  logic [CFG_DW-1:0]         out_len_reg;
  logic                      zero_phase_reg;
  int unsigned               loaded;
  int unsigned               next_pos;
  frame_result_t             expected_samples [$];
  int                        error_count;

  // A length of zero acts as one, anything above the frame store as the full store.
  function automatic int unsigned effective_length(input logic [CFG_DW-1:0] value);
    if (value == 0) return 1;
    if (value > FZ_MAX_FRAME) return FZ_MAX_FRAME;
    return 32'(value);
  endfunction

  function automatic logic [FZ_SAMPLE_BITS-1:0] stored_sample(input int unsigned idx);
    if (idx >= FZ_MAX_FRAME) return '0;
    return frame_mem[idx[IDX_W-1:0]];
  endfunction

  // Sample that lands at output position p for the current lengths and mode.
  function automatic logic [FZ_SAMPLE_BITS-1:0] resized_sample(input int unsigned p,
                                                                input int unsigned il,
                                                                input int unsigned ol);
    int unsigned half;
    int unsigned border;
    if (ol > il) begin
      if (zero_phase_reg) begin
        half = il >> 1;
        if (p < half) return stored_sample(p);
        if (p >= ol - half) return stored_sample(p - ol + 2 * half);
        return '0;
      end
      border = (ol - il) >> 1;
      if (p >= border && p < border + il) return stored_sample(p - border);
      return '0;
    end
    if (ol < il) begin
      if (zero_phase_reg) begin
        half = ol >> 1;
        if (p < half) return stored_sample(p);
        if (p < 2 * half) return stored_sample(il - 2 * half + p);
        return '0;
      end
      border = (il - ol) >> 1;
      return stored_sample(border + p);
    end
    return stored_sample(p);
  endfunction

  initial begin
    for (int i = 0; i < FZ_MAX_FRAME; i++) frame_mem[i[IDX_W-1:0]] = '0;
    error_count = 0;
  end

  always @(posedge clk) begin
    frame_result_t seen;
    frame_result_t want;
    int unsigned   il;
    int unsigned   ol;
    int unsigned   p;
    if (!rst_n) begin
      loaded         = 0;
      next_pos       = 0;
      in_len_reg     = CFG_DW'(1);
      out_len_reg    = CFG_DW'(1);
      zero_phase_reg = 1'b1;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IN_LEN:  in_len_reg = cfg_data;
          CFG_OUT_LEN: out_len_reg = cfg_data;
          CFG_ZPHASE:  zero_phase_reg = cfg_data[0];
          default: ;
        endcase
      end

      // Results are matched before new requests are predicted, so an empty queue
      // never pairs a result with a request taken on the same edge.
      if (out_valid && out_ready) begin
        seen = '{out_sample_out, out_index, out_last_of_frame, out_status};
        if (expected_samples.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%t: result with nothing expected: sample %h index %0d last %b status %b",
                     $realtime, seen.sample, seen.index, seen.last, seen.status);
          end
        end else begin
          want = expected_samples.pop_front();
          if (seen.sample !== want.sample || seen.index !== want.index ||
              seen.last !== want.last || seen.status !== want.status) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%t: mismatch: expected sample %h index %0d last %b status %b",
                       $realtime, want.sample, want.index, want.last, want.status);
              $display("%t:           got sample %h index %0d last %b status %b",
                       $realtime, seen.sample, seen.index, seen.last, seen.status);
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        il = effective_length(in_len_reg);
        ol = effective_length(out_len_reg);
        if (in_operation == OP_PUSH) begin
          if (loaded < il) begin
            frame_mem[loaded[IDX_W-1:0]] = in_sample_in;
            loaded++;
          end
        end else if (loaded < il) begin
          expected_samples.push_back('{'0, '0, 1'b0, STATUS_NOT_READY});
        end else begin
          p = (next_pos >= ol) ? 0 : next_pos;
          expected_samples.push_back('{resized_sample(p, il, ol), p[IDX_W-1:0],
                                       p == ol - 1, STATUS_OK});
          if (p == ol - 1) begin
            next_pos = 0;
            loaded   = 0;
          end else begin
            next_pos = p + 1;
          end
        end
      end
    end
    mismatches  <= error_count;
    outstanding <= expected_samples.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the frame zero-pad / resize testbench: clock, reset, stimulus and the verdict.
// Depends on fzpr_pkg, the frame_zero_pad_resize block and frame_resize_checker.

module testbench;
  import fzpr_pkg::*;

  localparam int IDX_W        = $clog2(FZ_MAX_FRAME);
  localparam int CYCLE_LIMIT  = 300000;
  localparam int ITEM_TARGET  = 1950;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int MAX_GAP      = 10;

  // Index 3 is not a register; a write to it must leave the block untouched.
  localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_operation;
  logic [FZ_SAMPLE_BITS-1:0] in_sample_in;
  logic                      out_valid;
  logic                      out_ready;
  logic [FZ_SAMPLE_BITS-1:0] out_sample_out;
  logic [IDX_W-1:0]          out_index;
  logic                      out_last_of_frame;
  logic                      out_status;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IW-1:0]         cfg_index;
  logic [CFG_DW-1:0]         cfg_data;

  int mismatches;
  int outstanding;
  int items_sent;
  bit burst;

  frame_zero_pad_resize DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_sample_in      (in_sample_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_index         (out_index),
    .out_last_of_frame (out_last_of_frame),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  frame_resize_checker frame_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_sample_in      (in_sample_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_index         (out_index),
    .out_last_of_frame (out_last_of_frame),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side. After each result the receiver draws a random stall bounded by MAX_GAP;
  // now and then it runs a stretch with no stalls at all. Twice it holds off for a long
  // stretch so that pulls pile up in the command queue and the block stops taking
  // requests while the sender keeps offering them.
  initial begin
    int  gap;
    int  taken;
    bit  calm;
    gap       = 0;
    taken     = 0;
    calm      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= (gap == 0);
      if (gap > 0) gap--;
      @(posedge clk);
      if (out_valid && out_ready) begin
        taken++;
        if (taken % 48 == 0) calm = ($urandom_range(0, 2) == 0);
        if (taken == 150 || taken == 700) gap = HOLD_CYCLES;
        else gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
    end
  end

  // The run ends here if the block hangs or a result never arrives.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Offers one request after a random gap and returns on the edge that accepts it.
  // Valid stays high across back-to-back requests, so each falling edge carries
  // exactly one assignment to it. A request counts in items_sent only when tally is set.
  task automatic send_request(input logic op, input logic [FZ_SAMPLE_BITS-1:0] smp,
                              input bit tally);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_sample_in <= smp;
    do @(posedge clk); while (!in_ready);
    if (tally) items_sent++;
  endtask

  // Full-scale values are favored so both rails of Q1.15 show up often.
  task automatic push_samples(input int count, input bit tally);
    int                        pick;
    logic [FZ_SAMPLE_BITS-1:0] smp;
    repeat (count) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) smp = 16'h8000;
      else if (pick == 1) smp = 16'h7FFF;
      else smp = 16'($urandom_range(0, 16'hFFFF));
      send_request(OP_PUSH, smp, tally);
    end
  endtask

  // The sample field is a don't-care on a pull, so it carries noise.
  task automatic pull_samples(input int count);
    repeat (count) send_request(OP_PULL, 16'($urandom_range(0, 16'hFFFF)), 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_lengths(input logic [CFG_DW-1:0] in_w, input logic [CFG_DW-1:0] out_w,
                             input logic zp);
    write_reg(CFG_IN_LEN, in_w);
    write_reg(CFG_OUT_LEN, out_w);
    write_reg(CFG_ZPHASE, {{(CFG_DW-1){1'b0}}, zp});
  endtask

  // Stops offering, waits for every predicted result, then lets pushes still queued
  // behind the last result drain before the registers may change.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int                il;
    int                ol;
    int                phase;
    int                shape;
    logic [CFG_DW-1:0] in_w;
    logic [CFG_DW-1:0] out_w;
    logic              zp;

    // Every input has a known value from time zero.
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_PUSH;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_IN_LEN;
    cfg_data     = '0;
    items_sent   = 0;
    burst        = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Reset leaves one-sample frames in zero-phase mode. A pull before
    // anything is loaded must report the frame as incomplete, and a second push into
    // a full frame must be dropped.
    send_request(OP_PULL, 16'h5A5A, 1'b1);
    send_request(OP_PUSH, 16'h8000, 1'b1);
    send_request(OP_PUSH, 16'h7FFF, 1'b0);
    send_request(OP_PULL, 16'hA5A5, 1'b1);
    wait_idle();
    write_reg(CFG_SPARE, '1);

    // Zero-phase padding with an odd input length: the last input sample is dropped.
    set_lengths(11'd3, 11'd5, 1'b1);
    send_request(OP_PUSH, 16'hFFFF, 1'b1);
    send_request(OP_PUSH, 16'h0001, 1'b1);
    send_request(OP_PUSH, 16'h7FFF, 1'b1);
    pull_samples(5);
    wait_idle();

    // Centered padding.
    set_lengths(11'd2, 11'd4, 1'b0);
    send_request(OP_PUSH, 16'h8000, 1'b1);
    send_request(OP_PUSH, 16'h7FFF, 1'b1);
    pull_samples(4);
    wait_idle();

    // Zero-phase truncation keeps both edges.
    set_lengths(11'd4, 11'd2, 1'b1);
    send_request(OP_PUSH, 16'h1111, 1'b1);
    send_request(OP_PUSH, 16'h2222, 1'b1);
    send_request(OP_PUSH, 16'h3333, 1'b1);
    send_request(OP_PUSH, 16'h4444, 1'b1);
    pull_samples(2);
    wait_idle();

    // Centered truncation, with an output length of zero that must act as one.
    set_lengths(11'd3, 11'd0, 1'b0);
    send_request(OP_PUSH, 16'hAAAA, 1'b1);
    send_request(OP_PUSH, 16'h5555, 1'b1);
    send_request(OP_PUSH, 16'h0000, 1'b1);
    pull_samples(1);
    wait_idle();

    // Random part, one configuration per phase. Phase 2 loads the largest input frame
    // through an over-range length; phase 5 pads to the largest output frame and stops
    // partway, so the next, shorter setting restarts output from position zero.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      burst = ($urandom_range(0, 3) == 0);
      zp    = logic'($urandom_range(0, 1));
      if (phase == 2) begin
        il    = FZ_MAX_FRAME;
        ol    = $urandom_range(1, 12);
        in_w  = '1;
        out_w = CFG_DW'(ol);
      end else if (phase == 5) begin
        il    = $urandom_range(1, 8);
        ol    = FZ_MAX_FRAME;
        in_w  = CFG_DW'(il);
        out_w = CFG_DW'(FZ_MAX_FRAME);
      end else begin
        il    = $urandom_range(1, 24);
        ol    = ($urandom_range(0, 4) == 0) ? il : $urandom_range(1, 24);
        in_w  = (il == 1 && $urandom_range(0, 1) == 1) ? '0 : CFG_DW'(il);
        out_w = (ol == 1 && $urandom_range(0, 1) == 1) ? '0 : CFG_DW'(ol);
      end
      set_lengths(in_w, out_w, zp);

      if (phase == 2) begin
        push_samples(il, 1'b1);
        pull_samples(ol);
      end else if (phase == 5) begin
        push_samples(il, 1'b1);
        pull_samples(300);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          burst = ($urandom_range(0, 3) == 0);
          shape = $urandom_range(0, 9);
          if (shape < 7) begin
            // A whole frame in, a whole frame out; sometimes with an early pull
            // halfway through loading or surplus pushes after the frame is full.
            if (shape == 0 && il > 1) begin
              push_samples(il / 2, 1'b1);
              pull_samples(1);
              push_samples(il - il / 2, 1'b1);
            end else begin
              push_samples(il, 1'b1);
            end
            if (shape == 1) push_samples($urandom_range(1, 3), 1'b0);
            pull_samples(ol);
          end else if (shape == 7) begin
            // An incomplete frame followed by pulls that find it not ready.
            push_samples($urandom_range(0, il - 1), 1'b1);
            pull_samples($urandom_range(1, 3));
          end else begin
            repeat ($urandom_range(1, 10)) begin
              send_request(logic'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
                           1'b1);
            end
          end
        end
      end
      wait_idle();
    end

    // Every phase ends idle, so nothing is outstanding here unless a result went missing.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fzpr_pkg.sv
hw/rtl/fzpr_front.sv
hw/rtl/fzpr_queue.sv
hw/rtl/fzpr_back.sv
hw/rtl/frame_zero_pad_resize.sv
tb/frame_resize_checker.sv
tb/testbench.sv
